/* rtl/core/sctg_pkg.sv */
// Shared types and constants for the scrolling two-color gradient block.
package sctg_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int MAX_LEDS          = 1024;
   localparam int QUEUE_DEPTH       = 2;

   localparam int LED_INDEX_W = 10;
   localparam int DT_W        = 16;
   localparam int SPEED_W     = 16;
   localparam int COLOR_W     = 24;
   localparam int ELAPSED_W   = 32;
   localparam int LENGTH_W    = 11;
   localparam int DIVISOR_W   = LENGTH_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLED      = 3'd0,
      CSR_COLOR_START  = 3'd1,
      CSR_COLOR_END    = 3'd2,
      CSR_SPEED        = 3'd3,
      CSR_DURATION_MS  = 3'd4,
      CSR_STRIP_LENGTH = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_PIXEL  = 2'd1,
      CMD_FLAT   = 2'd2,
      CMD_BYPASS = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      logic                   operation;
      logic [DT_W-1:0]        dt_ms;
      logic [LED_INDEX_W-1:0] led_index;
   } sctg_req_type;

   typedef struct packed {
      logic       pixel_valid;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       finished;
   } sctg_rsp_type;

   typedef struct packed {
      logic                 enabled;
      logic [COLOR_W-1:0]   color_start;
      logic [COLOR_W-1:0]   color_end;
      logic [SPEED_W-1:0]   speed;
      logic [ELAPSED_W-1:0] duration_ms;
      logic [LENGTH_W-1:0]  strip_length;
   } sctg_cfg_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [DT_W-1:0]        dt_ms;
      logic [LED_INDEX_W-1:0] led_index;
      logic [DIVISOR_W-1:0]   divisor;
   } sctg_cmd_type;

endpackage

/* rtl/core/sctg_csr.sv */
// Configuration register file of the gradient block.
module sctg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [sctg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sctg_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output sctg_pkg::sctg_cfg_type              cfg
);

   sctg_pkg::sctg_cfg_type cfg_ff;
   sctg_pkg::sctg_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            sctg_pkg::CSR_ENABLED:      cfg_in.enabled      = csr_wdata[0];
            sctg_pkg::CSR_COLOR_START:  cfg_in.color_start  =
                                           csr_wdata[sctg_pkg::COLOR_W-1:0];
            sctg_pkg::CSR_COLOR_END:    cfg_in.color_end    =
                                           csr_wdata[sctg_pkg::COLOR_W-1:0];
            sctg_pkg::CSR_SPEED:        cfg_in.speed        =
                                           csr_wdata[sctg_pkg::SPEED_W-1:0];
            sctg_pkg::CSR_DURATION_MS:  cfg_in.duration_ms  =
                                           csr_wdata[sctg_pkg::ELAPSED_W-1:0];
            sctg_pkg::CSR_STRIP_LENGTH: cfg_in.strip_length =
                                           csr_wdata[sctg_pkg::LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled      <= 1'b0;
         cfg_ff.color_start  <= '1;
         cfg_ff.color_end    <= '1;
         cfg_ff.speed        <= '0;
         cfg_ff.duration_ms  <= '0;
         cfg_ff.strip_length <= sctg_pkg::LENGTH_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/sctg_front.sv */
// Front end: takes request words, classifies them and pushes commands.
module sctg_front (
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sctg_pkg::sctg_req_type req_data,
   input  sctg_pkg::sctg_cfg_type cfg,
   input  logic                   queue_full,
   output logic                   push,
   output sctg_pkg::sctg_cmd_type push_cmd
);

   logic [sctg_pkg::LENGTH_W-1:0] len_eff;
   logic                          too_long;
   logic                          flat;

   // clamp the strip to the supported number of LEDs
   assign too_long = {{(32 - sctg_pkg::LENGTH_W){1'b0}}, cfg.strip_length}
                     > 32'(sctg_pkg::MAX_LEDS);
   assign len_eff  = too_long ? sctg_pkg::LENGTH_W'(sctg_pkg::MAX_LEDS)
                              : cfg.strip_length;
   assign flat     = len_eff <= sctg_pkg::LENGTH_W'(1);

   always_comb begin
      push_cmd.dt_ms     = req_data.dt_ms;
      push_cmd.led_index = req_data.led_index;
      push_cmd.divisor   = len_eff - sctg_pkg::LENGTH_W'(1);
      if (!cfg.enabled) begin
         push_cmd.kind = sctg_pkg::CMD_BYPASS;
      end else if (req_data.operation == sctg_pkg::OP_TICK) begin
         push_cmd.kind = sctg_pkg::CMD_TICK;
      end else if (flat) begin
         push_cmd.kind = sctg_pkg::CMD_FLAT;
      end else begin
         push_cmd.kind = sctg_pkg::CMD_PIXEL;
      end
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

endmodule

/* rtl/core/sctg_queue.sv */
// Short command queue between the front end and the back end.
module sctg_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sctg_pkg::sctg_cmd_type push_cmd,
   input  logic                   pop,
   output sctg_pkg::sctg_cmd_type head_cmd,
   output logic                   full,
   output logic                   empty
);

   localparam int DEPTH = sctg_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   sctg_pkg::sctg_cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

/* rtl/core/sctg_back.sv */
// Back end: tick update, iterative position divide, color blend, output register.
module sctg_back #(
   parameter int FRAC_BITS = sctg_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sctg_pkg::sctg_cfg_type cfg,
   input  logic                   q_empty,
   input  sctg_pkg::sctg_cmd_type q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sctg_pkg::sctg_rsp_type rsp_data
);

   localparam int NUM_W   = FRAC_BITS + sctg_pkg::LED_INDEX_W;
   localparam int CNT_W   = $clog2(NUM_W);
   localparam int PHASE_W = FRAC_BITS + 1;
   localparam int PROD_W  = sctg_pkg::SPEED_W + sctg_pkg::DT_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int MIX_W   = FRAC_BITS + 10;
   localparam int DIV_W   = sctg_pkg::DIVISOR_W;
   localparam int EL_W    = sctg_pkg::ELAPSED_W;
   localparam logic [SUM_W-1:0] ONE_Q = SUM_W'(1) << FRAC_BITS;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_PHASE  = 6'b000010,
      ST_DIVIDE = 6'b000100,
      ST_FRAC   = 6'b001000,
      ST_MIX    = 6'b010000,
      ST_DONE   = 6'b100000
   } back_state_type;

   back_state_type           state_ff, state_in;
   logic [PHASE_W-1:0]       phase_ff, phase_in;
   logic [EL_W-1:0]          elapsed_ff, elapsed_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic [DIV_W-1:0]         rem_ff, rem_in;
   logic [DIV_W-1:0]         div_ff, div_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [FRAC_BITS-1:0]     t_ff, t_in;
   logic [1:0]               ch_ff, ch_in;
   logic                     pix_ff, pix_in;
   logic [7:0]               red_ff, red_in;
   logic [7:0]               green_ff, green_in;
   logic [7:0]               blue_ff, blue_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   sctg_pkg::sctg_rsp_type   rsp_data_ff, rsp_data_in;

   logic [EL_W:0]            elapsed_sum;
   logic [SUM_W-1:0]         phase_sum;
   logic [DIV_W:0]           trial;
   logic [DIV_W:0]           trial_sub;
   logic                     trial_ge;
   logic [7:0]               chan_a;
   logic [7:0]               chan_b;
   logic signed [8:0]        chan_diff;
   logic signed [FRAC_BITS:0] t_signed;
   logic signed [MIX_W-1:0]  mix_prod;
   logic signed [MIX_W-1:0]  mix_base;
   logic signed [MIX_W-1:0]  mix_sum;
   logic [7:0]               mix_byte;
   logic                     finished;
   logic                     out_free;

   // saturating elapsed-time update
   assign elapsed_sum = {1'b0, elapsed_ff} + (EL_W + 1)'(q_head.dt_ms);
   assign phase_sum   = SUM_W'(phase_ff) + SUM_W'(prod_ff);

   // one quotient bit per cycle
   assign trial     = {rem_ff, num_ff[NUM_W-1]};
   assign trial_ge  = trial >= {1'b0, div_ff};
   assign trial_sub = trial - {1'b0, div_ff};

   always_comb begin
      case (ch_ff)
         CH_RED: begin
            chan_a = cfg.color_start[23:16];
            chan_b = cfg.color_end[23:16];
         end
         CH_GREEN: begin
            chan_a = cfg.color_start[15:8];
            chan_b = cfg.color_end[15:8];
         end
         default: begin
            chan_a = cfg.color_start[7:0];
            chan_b = cfg.color_end[7:0];
         end
      endcase
   end

   // a*(1-t) + b*t rewritten as a*1 + (b-a)*t
   assign chan_diff = $signed({1'b0, chan_b}) - $signed({1'b0, chan_a});
   assign t_signed  = $signed({1'b0, t_ff});
   assign mix_prod  = MIX_W'(chan_diff) * MIX_W'(t_signed);
   assign mix_base  = $signed({2'b00, chan_a, {FRAC_BITS{1'b0}}});
   assign mix_sum   = mix_base + mix_prod;
   assign mix_byte  = mix_sum[FRAC_BITS+7:FRAC_BITS];

   assign finished = !cfg.enabled ||
                     (cfg.duration_ms != '0 && elapsed_ff >= cfg.duration_ms);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      elapsed_in   = elapsed_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      cnt_in       = cnt_ff;
      t_in         = t_ff;
      ch_in        = ch_ff;
      pix_in       = pix_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               pix_in   = 1'b0;
               red_in   = '0;
               green_in = '0;
               blue_in  = '0;
               unique case (q_head.kind)
                  sctg_pkg::CMD_TICK: begin
                     elapsed_in = elapsed_sum[EL_W] ? '1 : elapsed_sum[EL_W-1:0];
                     prod_in    = PROD_W'(cfg.speed) * PROD_W'(q_head.dt_ms);
                     state_in   = ST_PHASE;
                  end
                  sctg_pkg::CMD_PIXEL: begin
                     pix_in   = 1'b1;
                     num_in   = {q_head.led_index, {FRAC_BITS{1'b0}}};
                     rem_in   = '0;
                     div_in   = q_head.divisor;
                     cnt_in   = CNT_W'(NUM_W - 1);
                     state_in = ST_DIVIDE;
                  end
                  sctg_pkg::CMD_FLAT: begin
                     pix_in   = 1'b1;
                     num_in   = '0;
                     state_in = ST_FRAC;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_PHASE: begin
            // past 1.0 the phase drops to zero
            phase_in = (phase_sum > ONE_Q) ? '0 : phase_sum[PHASE_W-1:0];
            state_in = ST_DONE;
         end
         ST_DIVIDE: begin
            rem_in = trial_ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
            num_in = {num_ff[NUM_W-2:0], trial_ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FRAC;
            end
         end
         ST_FRAC: begin
            t_in     = FRAC_BITS'(num_ff[FRAC_BITS-1:0] + phase_ff[FRAC_BITS-1:0]);
            ch_in    = CH_RED;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            case (ch_ff)
               CH_RED:   red_in   = mix_byte;
               CH_GREEN: green_in = mix_byte;
               default:  blue_in  = mix_byte;
            endcase
            ch_in = ch_ff + 2'd1;
            if (ch_ff == CH_BLUE) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.pixel_valid = pix_ff;
               rsp_data_in.red         = red_ff;
               rsp_data_in.green       = green_ff;
               rsp_data_in.blue        = blue_ff;
               rsp_data_in.finished    = finished;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      cnt_ff      <= cnt_in;
      t_ff        <= t_in;
      ch_ff       <= ch_in;
      pix_ff      <= pix_in;
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(phase_ff) <= ONE_Q)
      else $error("phase above one");

   a_elapsed_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> elapsed_ff >= $past(elapsed_ff))
      else $error("elapsed time went backward");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> div_ff != '0)
      else $error("divide by zero reached the divider");

   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result word loaded outside done state");
`endif

endmodule

/* rtl/core/scrolling_two_color_gradient_top.sv */
// Top level of the scrolling two-color gradient generator.
//
//   channel   direction  handshake         payload
//   req_      in         valid / stall     operation, dt_ms, led_index
//   rsp_      out        valid / stall     pixel_valid, red, green, blue, finished
//   csr_      in         write enable      index, 32-bit write data
//
// A tick goes from the queue head through the phase and done states to the result
// register; a pixel request runs the restoring divider, one quotient bit per cycle,
// then the fraction, blend and done states, and on a short strip skips the divider.
// One word is worked on at a time; a two-entry queue keeps taking requests.
// Reset is synchronous and clears control state, phase and elapsed time.
// A stalled result holds in the output register while the back end runs on.
module scrolling_two_color_gradient_top #(
   parameter int FRAC_BITS = sctg_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sctg_pkg::sctg_req_type           req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sctg_pkg::sctg_rsp_type           rsp_data,
   input  logic                             csr_we,
   input  logic [sctg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sctg_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   sctg_pkg::sctg_cfg_type cfg;
   sctg_pkg::sctg_cmd_type push_cmd;
   sctg_pkg::sctg_cmd_type head_cmd;
   logic                   push;
   logic                   pop;
   logic                   q_full;
   logic                   q_empty;

   sctg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sctg_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cfg        (cfg),
      .queue_full (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   sctg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   sctg_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (q_empty),
      .q_head    (head_cmd),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/sctg_gradient_monitor.sv */
// Gradient monitor: tracks register writes, predicts each result word and compares it.
module sctg_gradient_monitor
   import sctg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  sctg_req_type           req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  sctg_rsp_type           rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned            mismatch_count,
   output int unsigned            words_pending
);

   localparam int unsigned PRINT_CAP = 50;

   sctg_cfg_type  settings;
   logic [16:0]   gradient_phase;
   logic [31:0]   elapsed_ms;
   sctg_rsp_type  expected_words[$];
   int unsigned   errors = 0;
   int unsigned   words_checked = 0;

   initial begin
      mismatch_count = 0;
      words_pending  = 0;
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      errors++;
      if (errors <= PRINT_CAP)
         $display("mismatch on result word %0d: %s got %0h want %0h",
                  words_checked, what, got, want);
   endtask

   function automatic logic [7:0] blend_channel(input logic [7:0] a, input logic [7:0] b,
                                                input logic [15:0] frac);
      logic [31:0] acc;
      acc = 32'(a) * (32'h1_0000 - 32'(frac)) + 32'(b) * 32'(frac);
      return acc[23:16];
   endfunction

   // While enabled, advance the phase and elapsed time for a tick, or blend one LED for a pixel.
   function automatic sctg_rsp_type predict_gradient_word(input sctg_req_type w);
      sctg_rsp_type r;
      logic [32:0]  elapsed_sum;
      logic [33:0]  phase_sum;
      logic [10:0]  eff_len;
      logic [25:0]  pos;
      logic [15:0]  frac;
      r = '0;
      if (w.operation == OP_TICK) begin
         if (settings.enabled) begin
            elapsed_sum = {1'b0, elapsed_ms} + 33'(w.dt_ms);
            elapsed_ms  = elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
            phase_sum   = 34'(gradient_phase) + 34'(settings.speed) * 34'(w.dt_ms);
            // past 1.0 drops to zero, exactly 1.0 holds
            gradient_phase = (phase_sum > 34'h1_0000) ? 17'd0 : phase_sum[16:0];
         end
      end else if (settings.enabled) begin
         eff_len = (settings.strip_length > 11'(MAX_LEDS)) ? 11'(MAX_LEDS)
                                                           : settings.strip_length;
         pos = '0;
         if (eff_len > 11'd1) pos = {w.led_index, 16'h0000} / 26'(eff_len - 11'd1);
         frac = pos[15:0] + gradient_phase[15:0];
         r.pixel_valid = 1'b1;
         r.red   = blend_channel(settings.color_start[23:16], settings.color_end[23:16], frac);
         r.green = blend_channel(settings.color_start[15:8], settings.color_end[15:8], frac);
         r.blue  = blend_channel(settings.color_start[7:0], settings.color_end[7:0], frac);
      end
      if (!settings.enabled)
         r.finished = 1'b1;
      else
         r.finished = (settings.duration_ms != 0) && (elapsed_ms >= settings.duration_ms);
      return r;
   endfunction

   always @(posedge clock) begin
      sctg_rsp_type want;
      if (reset) begin
         settings.enabled      = 1'b0;
         settings.color_start  = 24'hFF_FFFF;
         settings.color_end    = 24'hFF_FFFF;
         settings.speed        = '0;
         settings.duration_ms  = '0;
         settings.strip_length = 11'd1;
         gradient_phase        = '0;
         elapsed_ms            = '0;
         expected_words.delete();
      end else begin
         // check the result before queueing a new word: a result never overtakes its word
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               flag_mismatch("unexpected word", 32'(rsp_data), 32'd0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.pixel_valid !== want.pixel_valid)
                  flag_mismatch("pixel_valid", 32'(rsp_data.pixel_valid),
                                32'(want.pixel_valid));
               if (rsp_data.red !== want.red)
                  flag_mismatch("red", 32'(rsp_data.red), 32'(want.red));
               if (rsp_data.green !== want.green)
                  flag_mismatch("green", 32'(rsp_data.green), 32'(want.green));
               if (rsp_data.blue !== want.blue)
                  flag_mismatch("blue", 32'(rsp_data.blue), 32'(want.blue));
               if (rsp_data.finished !== want.finished)
                  flag_mismatch("finished", 32'(rsp_data.finished), 32'(want.finished));
            end
            words_checked++;
         end
         if (req_valid && !req_stall)
            expected_words.push_back(predict_gradient_word(req_data));
         if (csr_we) begin
            case (csr_index)
               CSR_ENABLED:      settings.enabled      = csr_wdata[0];
               CSR_COLOR_START:  settings.color_start  = csr_wdata[23:0];
               CSR_COLOR_END:    settings.color_end    = csr_wdata[23:0];
               CSR_SPEED:        settings.speed        = csr_wdata[15:0];
               CSR_DURATION_MS:  settings.duration_ms  = csr_wdata;
               CSR_STRIP_LENGTH: settings.strip_length = csr_wdata[10:0];
               default: ;
            endcase
         end
      end
      words_pending  <= expected_words.size();
      mismatch_count <= errors;
   end

endmodule

/* tb/scrolling_two_color_gradient_top_test.sv */
// Stimulus and verdict for the scrolling two-color gradient block.
module scrolling_two_color_gradient_top_test;
   import sctg_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 3_000_000;
   localparam int unsigned PHASES       = 9;
   localparam int unsigned PHASE_WORDS  = 190;
   localparam int unsigned SAT_TICKS    = 40;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   sctg_req_type           req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   sctg_rsp_type           rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int unsigned mismatch_count;
   int unsigned words_pending;
   int unsigned cycle_count     = 0;
   int unsigned ticks_sent      = 0;
   int unsigned pixels_sent     = 0;
   int unsigned settings_loaded = 0;
   bit          idle_on         = 1'b1;
   bit          stall_on        = 1'b1;

   scrolling_two_color_gradient_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sctg_gradient_monitor u_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count, words_pending);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic push_word(input sctg_req_type w);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      if (w.operation == OP_TICK) ticks_sent++;
      else pixels_sent++;
   endtask

   task automatic send_tick(input logic [DT_W-1:0] dt);
      push_word('{operation: OP_TICK, dt_ms: dt, led_index: 10'($urandom)});
   endtask

   task automatic send_pixel(input logic [LED_INDEX_W-1:0] idx);
      push_word('{operation: OP_PIXEL, dt_ms: 16'($urandom), led_index: idx});
   endtask

   // Drop valid and hold until every expected word is back.
   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
   endtask

   task automatic load_settings(input sctg_cfg_type c);
      csr_index_type        idx;
      logic [CSR_DATA_W-1:0] value;
      idx = idx.first();
      do begin
         case (idx)
            CSR_ENABLED:      value = 32'(c.enabled);
            CSR_COLOR_START:  value = 32'(c.color_start);
            CSR_COLOR_END:    value = 32'(c.color_end);
            CSR_SPEED:        value = 32'(c.speed);
            CSR_DURATION_MS:  value = c.duration_ms;
            default:          value = 32'(c.strip_length);
         endcase
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value;
         @(posedge clock);
         idx = idx.next();
      end while (idx != idx.first());
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   function automatic sctg_cfg_type pick_settings(input int unsigned k);
      sctg_cfg_type c;
      c.enabled      = (k != 3);
      c.color_start  = 24'($urandom);
      c.color_end    = 24'($urandom);
      c.speed        = 16'($urandom_range(0, 255));
      c.duration_ms  = $urandom;
      c.strip_length = 11'($urandom_range(1, MAX_LEDS));
      case (k)
         0: begin
            c.color_start = '0;
            c.color_end   = '1;
            c.duration_ms = '0;
         end
         1: begin
            c.color_start  = '1;
            c.color_end    = '0;
            c.speed        = 16'hFFFF;
            c.duration_ms  = $urandom_range(1, 5000);
            c.strip_length = 11'(MAX_LEDS);
         end
         2: c.strip_length = 11'd2;
         4: begin
            c.speed        = '0;
            c.duration_ms  = 32'hFFFF_FFFF;
            c.strip_length = '0;
         end
         5: begin
            c.duration_ms  = $urandom_range(1, 200_000);
            c.strip_length = 11'h7FF;
         end
         6: begin
            c.speed        = 16'($urandom);
            c.duration_ms  = '0;
            c.strip_length = 11'd1;
         end
         8: begin
            c.duration_ms  = $urandom_range(1, 1000);
            c.strip_length = 11'd3;
         end
         default: ;
      endcase
      return c;
   endfunction

   function automatic sctg_req_type random_word(input int unsigned span);
      sctg_req_type w;
      w.operation = $urandom_range(0, 1) ? OP_PIXEL : OP_TICK;
      // mostly short ticks so the phase lives a while before it overflows
      w.dt_ms = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
      w.led_index = $urandom_range(0, 1) ? 10'($urandom) : 10'($urandom_range(0, span - 1));
      return w;
   endfunction

   // Receive side: stall a random number of cycles ahead of each word.
   initial begin
      int unsigned hold;
      rsp_stall = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         hold = stall_on ? $urandom_range(0, 6) : 0;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid || rsp_stall);
      end
   end

   initial begin
      sctg_cfg_type cfg;
      int unsigned  span;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // out of reset the effect is off
      send_tick(16'd5);
      send_pixel(10'd0);
      drain();

      cfg = '{enabled: 1'b1, color_start: 24'hFF0080, color_end: 24'h00FF7F,
              speed: 16'h8000, duration_ms: 32'd100, strip_length: 11'd1024};
      load_settings(cfg);
      send_pixel(10'd0);
      send_pixel(10'd1023);
      send_pixel(10'd511);
      send_tick(16'd0);
      send_tick(16'd2);          // lands exactly on 1.0
      send_pixel(10'd300);
      send_tick(16'd1);          // past 1.0, back to zero
      send_pixel(10'd300);
      send_tick(16'hFFFF);       // duration reached
      send_pixel(10'd1023);
      drain();

      cfg.strip_length = 11'd1;
      load_settings(cfg);
      send_pixel(10'd5);
      send_pixel(10'd1023);
      drain();

      cfg.strip_length = 11'd0;
      load_settings(cfg);
      send_pixel(10'd7);
      drain();

      cfg.strip_length = 11'h7FF;
      load_settings(cfg);
      send_pixel(10'd1023);
      send_pixel(10'd512);
      drain();

      // index far beyond a two-LED strip wraps through the modulo
      cfg.strip_length = 11'd2;
      load_settings(cfg);
      send_pixel(10'd1023);
      send_pixel(10'd1);
      drain();

      cfg.enabled = 1'b0;
      load_settings(cfg);
      send_tick(16'd100);
      send_pixel(10'd4);
      drain();

      for (int unsigned k = 0; k < PHASES; k++) begin
         cfg = pick_settings(k);
         load_settings(cfg);
         idle_on  = (k % 3 != 1);
         stall_on = (k % 3 != 2);
         span = (cfg.strip_length == 0) ? 1 :
                (cfg.strip_length > MAX_LEDS) ? MAX_LEDS : 32'(cfg.strip_length);
         for (int unsigned n = 0; n < PHASE_WORDS; n++)
            push_word(random_word(span));
         drain();
      end

      // back-to-back long ticks against the longest duration
      idle_on  = 1'b0;
      stall_on = 1'b0;
      cfg = pick_settings(PHASES);
      cfg.enabled     = 1'b1;
      cfg.duration_ms = 32'hFFFF_FFFF;
      load_settings(cfg);
      for (int unsigned n = 0; n < SAT_TICKS; n++)
         send_tick(16'hFFFF);
      for (int unsigned n = 0; n < 10; n++)
         push_word(random_word(MAX_LEDS));
      drain();

      idle_on  = 1'b1;
      stall_on = 1'b1;
      cfg.duration_ms = '0;
      load_settings(cfg);
      for (int unsigned n = 0; n < 20; n++)
         push_word(random_word(MAX_LEDS));
      drain();

      repeat (64) @(posedge clock);
      $display("covered %0d ticks and %0d pixel requests across %0d register settings",
               ticks_sent, pixels_sent, settings_loaded);
      $display("including %0d back-to-back maximum ticks against the longest duration",
               SAT_TICKS);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
